// File: src/assert_macros.svh
// assert_macros.svh: assertion macros shared by the lzss window decoder RTL.
// Uses the clock and reset names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, suspended while reset is high
`define LZWD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lzwd assertion failed");

// clocked check that also holds during reset
`define LZWD_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("lzwd assertion failed");

`endif

// File: src/lzwd_pkg.sv
// lzwd_pkg: constants and types of the lzss window decoder.
// Used by the controller, datapath and top level; depends on nothing.
package lzwd_pkg;

   localparam int WINDOW_BITS = 12;
   localparam int WIN_DEPTH   = 1 << WINDOW_BITS;
   localparam int FILL_W      = WINDOW_BITS + 1;
   localparam logic [WINDOW_BITS-1:0] WRITE_START = 12'hFEE;
   localparam int MIN_MATCH   = 3;
   localparam int LEN_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_EXPECTED_SIZE = 1'b0;

   typedef enum logic [1:0] {
      OP_FLAGS     = 2'd0,
      OP_LITERAL   = 2'd1,
      OP_PAIR_LOW  = 2'd2,
      OP_PAIR_HIGH = 2'd3
   } op_type;

   typedef struct packed {
      logic   accept;
      op_type op;
      logic   issue;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic flags_empty;
      logic flag_bit;
      logic pair_pending;
      logic remain_nz;
      logic pend;
      logic pend_final;
      logic slot_free;
   } sts_type;

endpackage

// File: src/lzwd_req_if.sv
// lzwd_req_if: input channel of the lzss window decoder (compressed bytes).
// Standalone; valid/ready handshake with source and sink modports.
interface lzwd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: src/lzwd_rsp_if.sv
// lzwd_rsp_if: result channel of the lzss window decoder (decoded bytes, status).
// Standalone; valid/ready handshake with source and sink modports.
interface lzwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_run;
   logic       size_mismatch;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_run, output size_mismatch, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_run, input size_mismatch, output ready);
endinterface

// File: src/lzwd_ram.sv
// lzwd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; used for the history window.
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: src/lzwd_ctrl.sv
// lzwd_ctrl: sequencer of the lzss window decoder; picks the item kind and runs copies.
// Depends on lzwd_pkg; drives the datapath through cmd_type, watches sts_type.
module lzwd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lzwd_pkg::sts_type sts,
   output lzwd_pkg::cmd_type cmd
);
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_COPY = 2'b10
   } state_type;

   state_type state_ff, state_in;
   lzwd_pkg::op_type op;

   always_comb begin
      priority if (sts.flags_empty) begin
         op = lzwd_pkg::OP_FLAGS;
      end else if (sts.flag_bit) begin
         op = lzwd_pkg::OP_LITERAL;
      end else if (!sts.pair_pending) begin
         op = lzwd_pkg::OP_PAIR_LOW;
      end else begin
         op = lzwd_pkg::OP_PAIR_HIGH;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.op     = op;
      cmd.issue  = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = sts.slot_free;
            cmd.accept = req_valid && sts.slot_free;
            if (cmd.accept && op == lzwd_pkg::OP_PAIR_HIGH) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            cmd.emit  = sts.pend && sts.slot_free;
            cmd.issue = sts.remain_nz && (!sts.pend || sts.slot_free);
            if (cmd.emit && sts.pend_final) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: src/lzwd_datapath.sv
// lzwd_datapath: decode state, history window, copy pipeline and result register.
// Depends on lzwd_pkg and lzwd_ram; commanded by lzwd_ctrl.
module lzwd_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  lzwd_pkg::cmd_type              cmd,
   input  logic [lzwd_pkg::BYTE_W-1:0]    in_byte,
   input  logic                           in_last,
   input  logic [lzwd_pkg::COUNT_W-1:0]   expected_size,
   input  logic                           out_ready,
   output lzwd_pkg::sts_type              sts,
   output logic                           out_valid,
   output logic [lzwd_pkg::BYTE_W-1:0]    out_byte,
   output logic                           byte_valid,
   output logic                           end_of_run,
   output logic                           size_mismatch
);
   localparam int WB = lzwd_pkg::WINDOW_BITS;

   // decode state
   logic [7:0]                       flag_bits_ff;
   logic [3:0]                       flags_left_ff;
   logic                             pair_pending_ff;
   logic [7:0]                       pair_low_ff;
   logic [WB-1:0]                    wp_ff;
   logic [lzwd_pkg::FILL_W-1:0]      fill_ff;
   logic [lzwd_pkg::COUNT_W-1:0]     count_ff;
   logic                             ovf_ff;
   // copy pipeline
   logic [WB-1:0]                    rd_ff;
   logic [lzwd_pkg::LEN_W-1:0]       remain_ff;
   logic                             last_ff;
   logic                             pend_ff;
   logic                             pend_final_ff;
   logic                             hit_ff;
   logic                             vld_ff;
   logic [7:0]                       fwd_ff;
   // result register
   logic                             out_vld_ff;
   logic [7:0]                       out_byte_ff;
   logic                             out_bv_ff;
   logic                             out_eor_ff;
   logic                             out_mis_ff;

   logic [7:0]                       ram_rdata;
   logic [7:0]                       data_sel;
   logic [lzwd_pkg::COUNT_W:0]       count_inc;
   logic                             ovf_inc;
   logic                             mis_data;
   logic                             mis_stat;
   logic                             is_lit;
   logic                             is_stat;
   logic                             wr_en;
   logic [7:0]                       wr_data;
   logic                             end_blk;
   logic                             load;
   logic [WB-1:0]                    rd_ofs;
   logic                             rd_valid;

   lzwd_ram #(
      .WIDTH (lzwd_pkg::BYTE_W),
      .DEPTH (lzwd_pkg::WIN_DEPTH)
   ) u_history (
      .clock (clock),
      .we    (wr_en),
      .waddr (wp_ff),
      .wdata (wr_data),
      .re    (cmd.issue),
      .raddr (rd_ff),
      .rdata (ram_rdata)
   );

   // entries past the fill count were not written in this block and read as zero
   assign rd_ofs   = rd_ff - lzwd_pkg::WRITE_START;
   assign rd_valid = {1'b0, rd_ofs} < fill_ff;
   assign data_sel = hit_ff ? fwd_ff : (vld_ff ? ram_rdata : 8'd0);

   assign count_inc = {1'b0, count_ff} + {{lzwd_pkg::COUNT_W{1'b0}}, 1'b1};
   assign ovf_inc   = ovf_ff | count_inc[lzwd_pkg::COUNT_W];
   assign mis_data  = ovf_inc | (count_inc[lzwd_pkg::COUNT_W-1:0] != expected_size);
   assign mis_stat  = ovf_ff | (count_ff != expected_size);

   assign is_lit  = cmd.accept && cmd.op == lzwd_pkg::OP_LITERAL;
   assign is_stat = cmd.accept && in_last &&
                    (cmd.op == lzwd_pkg::OP_FLAGS || cmd.op == lzwd_pkg::OP_PAIR_LOW);
   assign wr_en   = is_lit || cmd.emit;
   assign wr_data = cmd.emit ? data_sel : in_byte;
   assign end_blk = (cmd.accept && in_last && cmd.op != lzwd_pkg::OP_PAIR_HIGH) ||
                    (cmd.emit && pend_final_ff && last_ff);
   assign load    = wr_en || is_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_bits_ff    <= 8'd0;
         flags_left_ff   <= 4'd0;
         pair_pending_ff <= 1'b0;
         wp_ff           <= lzwd_pkg::WRITE_START;
         fill_ff         <= '0;
         count_ff        <= '0;
         ovf_ff          <= 1'b0;
         remain_ff       <= '0;
         last_ff         <= 1'b0;
         pend_ff         <= 1'b0;
         pend_final_ff   <= 1'b0;
         out_vld_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            wp_ff    <= wp_ff + {{(WB-1){1'b0}}, 1'b1};
            count_ff <= count_inc[lzwd_pkg::COUNT_W-1:0];
            ovf_ff   <= ovf_inc;
            if (!fill_ff[lzwd_pkg::FILL_W-1]) begin
               fill_ff <= fill_ff + {{(lzwd_pkg::FILL_W-1){1'b0}}, 1'b1};
            end
         end
         if (cmd.accept) begin
            unique case (cmd.op)
               lzwd_pkg::OP_FLAGS: begin
                  flag_bits_ff  <= in_byte;
                  flags_left_ff <= 4'd8;
               end
               lzwd_pkg::OP_LITERAL: begin
                  flag_bits_ff  <= flag_bits_ff >> 1;
                  flags_left_ff <= flags_left_ff - 4'd1;
               end
               lzwd_pkg::OP_PAIR_LOW: begin
                  pair_pending_ff <= 1'b1;
               end
               lzwd_pkg::OP_PAIR_HIGH: begin
                  pair_pending_ff <= 1'b0;
                  flag_bits_ff    <= flag_bits_ff >> 1;
                  flags_left_ff   <= flags_left_ff - 4'd1;
                  remain_ff       <= {1'b0, in_byte[3:0]} + lzwd_pkg::LEN_W'(lzwd_pkg::MIN_MATCH);
                  last_ff         <= in_last;
               end
               default: begin
               end
            endcase
         end
         if (cmd.issue) begin
            remain_ff     <= remain_ff - {{(lzwd_pkg::LEN_W-1){1'b0}}, 1'b1};
            pend_ff       <= 1'b1;
            pend_final_ff <= remain_ff == {{(lzwd_pkg::LEN_W-1){1'b0}}, 1'b1};
         end else if (cmd.emit) begin
            pend_ff <= 1'b0;
         end
         if (load) begin
            out_vld_ff <= 1'b1;
         end else if (out_ready) begin
            out_vld_ff <= 1'b0;
         end
         if (end_blk) begin
            flag_bits_ff    <= 8'd0;
            flags_left_ff   <= 4'd0;
            pair_pending_ff <= 1'b0;
            wp_ff           <= lzwd_pkg::WRITE_START;
            fill_ff         <= '0;
            count_ff        <= '0;
            ovf_ff          <= 1'b0;
            last_ff         <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && cmd.op == lzwd_pkg::OP_PAIR_LOW) begin
         pair_low_ff <= in_byte;
      end
      if (cmd.accept && cmd.op == lzwd_pkg::OP_PAIR_HIGH) begin
         rd_ff <= {in_byte[7:4], pair_low_ff};
      end else if (cmd.issue) begin
         rd_ff  <= rd_ff + {{(WB-1){1'b0}}, 1'b1};
         // same-cycle write to the address being read is forwarded
         hit_ff <= cmd.emit && rd_ff == wp_ff;
         vld_ff <= rd_valid;
         fwd_ff <= data_sel;
      end
      if (load) begin
         out_byte_ff <= cmd.emit ? data_sel : (is_lit ? in_byte : 8'd0);
         out_bv_ff   <= wr_en;
         out_eor_ff  <= is_lit || is_stat || (cmd.emit && pend_final_ff);
         out_mis_ff  <= end_blk && (wr_en ? mis_data : mis_stat);
      end
   end

   assign sts.flags_empty  = flags_left_ff == 4'd0;
   assign sts.flag_bit     = flag_bits_ff[0];
   assign sts.pair_pending = pair_pending_ff;
   assign sts.remain_nz    = remain_ff != '0;
   assign sts.pend         = pend_ff;
   assign sts.pend_final   = pend_final_ff;
   assign sts.slot_free    = !out_vld_ff || out_ready;

   assign out_valid     = out_vld_ff;
   assign out_byte      = out_byte_ff;
   assign byte_valid    = out_bv_ff;
   assign end_of_run    = out_eor_ff;
   assign size_mismatch = out_mis_ff;
endmodule

// File: src/lzss_window_decoder.sv
// LZSS decoder with a 4096-byte history window. Compressed payload bytes enter one
// item at a time on req_chan; decoded bytes leave one item at a time on rsp_chan. A flag
// byte, a literal or the first byte of a match pair is decoded as it is accepted. The second
// byte of a pair starts a copy of length L (3 to 18): the history RAM gives one read and
// one write per cycle and its read data is registered, so one decoded byte leaves per
// cycle while rsp_chan does not stall. The history is cleared at reset and at end of
// block by a fill count, so no clearing pass is needed and an item may be taken in the
// cycle after reset. On the item marked last, size_mismatch reports whether the decoded
// byte count of the block differs from expected_size (csr address 0); a status-only
// item carries it when the last byte decodes to nothing.
// Depends on lzwd_pkg, lzwd_req_if, lzwd_rsp_if, lzwd_ctrl, lzwd_datapath, lzwd_ram.
`include "assert_macros.svh"

module lzss_window_decoder (
   input  logic                            clock,
   input  logic                            reset,
   lzwd_req_if.sink                        req_chan,
   lzwd_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lzwd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lzwd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lzwd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   lzwd_pkg::cmd_type             cmd;
   lzwd_pkg::sts_type             sts;
   logic [lzwd_pkg::COUNT_W-1:0]  expected_ff;
   logic                          reg_sel;
   logic                          req_ready;

   assign reg_sel    = csr_paddr[2] == lzwd_pkg::REG_EXPECTED_SIZE;
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? expected_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         expected_ff <= csr_pwdata;
      end
   end

   lzwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   lzwd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .in_byte       (req_chan.in_byte),
      .in_last       (req_chan.in_last),
      .expected_size (expected_ff),
      .out_ready     (rsp_chan.ready),
      .sts           (sts),
      .out_valid     (rsp_chan.valid),
      .out_byte      (rsp_chan.out_byte),
      .byte_valid    (rsp_chan.byte_valid),
      .end_of_run    (rsp_chan.end_of_run),
      .size_mismatch (rsp_chan.size_mismatch)
   );

   `LZWD_ASSERT(a_accept_needs_slot, req_chan.valid && req_ready |-> !rsp_chan.valid || rsp_chan.ready)
   `LZWD_ASSERT(a_no_accept_in_copy, cmd.issue || cmd.emit |-> !req_ready)
   `LZWD_ASSERT(a_status_ends_run, rsp_chan.valid && !rsp_chan.byte_valid |-> rsp_chan.end_of_run)
   `LZWD_ASSERT(a_mismatch_on_end, rsp_chan.valid && rsp_chan.size_mismatch |-> rsp_chan.end_of_run)
   `LZWD_ASSERT_ALWAYS(a_emit_needs_data, cmd.emit |-> sts.pend)
endmodule
